### src/mcfe_pkg.sv
// ----------------------------------------------------------------------------
// Motor command frame encoder package
// Shared frame kinds, register map and fixed frame bytes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package mcfe_pkg;

	typedef enum logic [2:0] {
		KIND_CONTROL = 3'd0,
		KIND_ENABLE  = 3'd1,
		KIND_DISABLE = 3'd2,
		KIND_ZERO    = 3'd3,
		KIND_CLEAR   = 3'd4
	} frame_kind_t;

	localparam int CFG_ADDR_W = 5;
	localparam logic [2:0] REG_POS_LIMIT = 3'd0;
	localparam logic [2:0] REG_VEL_LIMIT = 3'd1;
	localparam logic [2:0] REG_TRQ_LIMIT = 3'd2;
	localparam logic [2:0] REG_KP_MIN    = 3'd3;
	localparam logic [2:0] REG_KP_MAX    = 3'd4;
	localparam logic [2:0] REG_KD_MIN    = 3'd5;
	localparam logic [2:0] REG_KD_MAX    = 3'd6;

	localparam logic [55:0] FIXED_PREFIX = 56'hFF_FFFF_FFFF_FFFF;
	localparam logic [7:0]  BYTE_ENABLE  = 8'hFC;
	localparam logic [7:0]  BYTE_DISABLE = 8'hFD;
	localparam logic [7:0]  BYTE_ZERO    = 8'hFE;
	localparam logic [7:0]  BYTE_CLEAR   = 8'hFB;

	localparam int POS_SLOT_W   = 16;
	localparam int OTHER_SLOT_W = 12;

endpackage

`default_nettype wire

### src/motor_command_frame_encoder_core.sv
// ----------------------------------------------------------------------------
// Motor command frame encoder core
// Turns one motor command beat into one 8-byte CAN payload beat.
// ----------------------------------------------------------------------------
// Input stream s_*: s_tdata carries the five Q16.16 commands, s_tuser the
// action and the online flag. Output stream m_*: m_tdata is the payload
// (byte zero in the top bits), m_tuser the frame kind and the clamp flag.
// Limits and gain ranges sit behind the APB port; write them while idle.
// Pipeline stages: clamp, subtract, multiply, one stage per quotient bit of
// the restoring divider, then the output register. One beat per cycle is
// taken and delivered when the sink keeps up.
// When m_tready is low the output register holds; upstream stages keep
// advancing into empty slots, so the block still takes beats until every
// stage is full, then s_tready drops. Nothing is lost or repeated.
// Reset clears all stage valid bits and loads the default limits.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module motor_command_frame_encoder_core #(
	parameter int POSITION_CODE_BITS = 16,
	parameter int OTHER_CODE_BITS    = 12
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           s_tvalid,
	output logic                                s_tready,
	// position, velocity, stiffness, damping, torque (32 bits each, lowest first)
	input  wire logic [159:0]                   s_tdata,
	// action [2:0], motor_online [3]
	input  wire logic [3:0]                     s_tuser,
	output logic                                m_tvalid,
	input  wire logic                           m_tready,
	// payload [63:0]
	output logic [63:0]                         m_tdata,
	// frame_kind [2:0], any_clamped [3]
	output logic [3:0]                          m_tuser,
	input  wire logic                           psel,
	input  wire logic                           penable,
	input  wire logic                           pwrite,
	input  wire logic [mcfe_pkg::CFG_ADDR_W-1:0] paddr,
	input  wire logic [31:0]                    pwdata,
	output logic [31:0]                         prdata,
	output logic                                pready
);
	import mcfe_pkg::*;

	localparam int W  = (POSITION_CODE_BITS > OTHER_CODE_BITS) ?
	                    POSITION_CODE_BITS : OTHER_CODE_BITS;
	localparam int LS = W + 3;
	localparam int NS = LS + 1;

	// configuration registers
	logic [30:0]        pos_lim_q, vel_lim_q, trq_lim_q;
	logic signed [31:0] kp_min_q, kp_max_q, kd_min_q, kd_max_q;
	logic               cfg_wr;
	logic [2:0]         cfg_idx;

	assign pready  = 1'b1;
	assign cfg_idx = paddr[4:2];
	assign cfg_wr  = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_lim_q <= 31'd819200;
			vel_lim_q <= 31'd1966080;
			trq_lim_q <= 31'd655360;
			kp_min_q  <= 32'sd0;
			kp_max_q  <= 32'sd32768000;
			kd_min_q  <= 32'sd0;
			kd_max_q  <= 32'sd327680;
		end else if (cfg_wr) begin
			case (cfg_idx)
				REG_POS_LIMIT: pos_lim_q <= pwdata[30:0];
				REG_VEL_LIMIT: vel_lim_q <= pwdata[30:0];
				REG_TRQ_LIMIT: trq_lim_q <= pwdata[30:0];
				REG_KP_MIN:    kp_min_q  <= pwdata;
				REG_KP_MAX:    kp_max_q  <= pwdata;
				REG_KD_MIN:    kd_min_q  <= pwdata;
				REG_KD_MAX:    kd_max_q  <= pwdata;
				default: ;
			endcase
		end
	end

	always_comb begin
		case (cfg_idx)
			REG_POS_LIMIT: prdata = {1'b0, pos_lim_q};
			REG_VEL_LIMIT: prdata = {1'b0, vel_lim_q};
			REG_TRQ_LIMIT: prdata = {1'b0, trq_lim_q};
			REG_KP_MIN:    prdata = kp_min_q;
			REG_KP_MAX:    prdata = kp_max_q;
			REG_KD_MIN:    prdata = kd_min_q;
			REG_KD_MAX:    prdata = kd_max_q;
			default:       prdata = '0;
		endcase
	end

	// stage advance: a stage moves when empty or when the next one moves
	logic [NS-1:0] vld_s;
	logic [NS-1:0] en;

	always_comb begin
		en[NS-1] = !vld_s[NS-1] || m_tready;
		for (int k = NS - 2; k >= 0; k--) begin
			en[k] = !vld_s[k] || en[k+1];
		end
	end

	assign s_tready = en[0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else begin
			if (en[0]) begin
				vld_s[0] <= s_tvalid;
			end
			for (int k = 1; k < NS; k++) begin
				if (en[k]) begin
					vld_s[k] <= vld_s[k-1];
				end
			end
		end
	end

	// frame kind decode rides alongside the lanes
	logic        ctl_in;
	frame_kind_t kind_in;
	logic        ctl_s  [LS];
	frame_kind_t kind_s [LS];

	always_comb begin
		ctl_in = (s_tuser[2:0] == KIND_CONTROL) && s_tuser[3];
		case (s_tuser[2:0])
			KIND_CONTROL: kind_in = s_tuser[3] ? KIND_CONTROL : KIND_ENABLE;
			KIND_ENABLE:  kind_in = KIND_ENABLE;
			KIND_ZERO:    kind_in = KIND_ZERO;
			KIND_CLEAR:   kind_in = KIND_CLEAR;
			default:      kind_in = KIND_DISABLE;
		endcase
	end

	always_ff @(posedge clk) begin
		if (en[0]) begin
			ctl_s[0]  <= ctl_in;
			kind_s[0] <= kind_in;
		end
		for (int k = 1; k < LS; k++) begin
			if (en[k]) begin
				ctl_s[k]  <= ctl_s[k-1];
				kind_s[k] <= kind_s[k-1];
			end
		end
	end

	// scaling lanes
	logic [W-1:0] code_p, code_v, code_kp, code_kd, code_t;
	logic         clp_p, clp_v, clp_kp, clp_kd, clp_t;

	mcfe_lane #(.W(W), .BITS(POSITION_CODE_BITS)) u_pos (
		.clk(clk), .arst_n(arst_n), .en(en[LS-1:0]),
		.x(s_tdata[31:0]),
		.lo(-33'sd0 - 33'($unsigned(pos_lim_q))), .hi(33'($unsigned(pos_lim_q))),
		.code(code_p), .clamped(clp_p)
	);

	mcfe_lane #(.W(W), .BITS(OTHER_CODE_BITS)) u_vel (
		.clk(clk), .arst_n(arst_n), .en(en[LS-1:0]),
		.x(s_tdata[63:32]),
		.lo(-33'sd0 - 33'($unsigned(vel_lim_q))), .hi(33'($unsigned(vel_lim_q))),
		.code(code_v), .clamped(clp_v)
	);

	mcfe_lane #(.W(W), .BITS(OTHER_CODE_BITS)) u_kp (
		.clk(clk), .arst_n(arst_n), .en(en[LS-1:0]),
		.x(s_tdata[95:64]),
		.lo(33'(kp_min_q)), .hi(33'(kp_max_q)),
		.code(code_kp), .clamped(clp_kp)
	);

	mcfe_lane #(.W(W), .BITS(OTHER_CODE_BITS)) u_kd (
		.clk(clk), .arst_n(arst_n), .en(en[LS-1:0]),
		.x(s_tdata[127:96]),
		.lo(33'(kd_min_q)), .hi(33'(kd_max_q)),
		.code(code_kd), .clamped(clp_kd)
	);

	mcfe_lane #(.W(W), .BITS(OTHER_CODE_BITS)) u_trq (
		.clk(clk), .arst_n(arst_n), .en(en[LS-1:0]),
		.x(s_tdata[159:128]),
		.lo(-33'sd0 - 33'($unsigned(trq_lim_q))), .hi(33'($unsigned(trq_lim_q))),
		.code(code_t), .clamped(clp_t)
	);

	// output register
	logic [63:0] out_data_q;
	frame_kind_t out_kind_q;
	logic        out_clp_q;
	logic [7:0]  tail_byte;

	always_comb begin
		case (kind_s[LS-1])
			KIND_ZERO:  tail_byte = BYTE_ZERO;
			KIND_CLEAR: tail_byte = BYTE_CLEAR;
			KIND_ENABLE: tail_byte = BYTE_ENABLE;
			default:    tail_byte = BYTE_DISABLE;
		endcase
	end

	always_ff @(posedge clk) begin
		if (en[NS-1]) begin
			if (ctl_s[LS-1]) begin
				out_data_q <= {POS_SLOT_W'(code_p), OTHER_SLOT_W'(code_v),
				               OTHER_SLOT_W'(code_kp), OTHER_SLOT_W'(code_kd),
				               OTHER_SLOT_W'(code_t)};
				out_clp_q  <= clp_p || clp_v || clp_kp || clp_kd || clp_t;
			end else begin
				out_data_q <= {FIXED_PREFIX, tail_byte};
				out_clp_q  <= 1'b0;
			end
			out_kind_q <= kind_s[LS-1];
		end
	end

	assign m_tvalid = vld_s[NS-1];
	assign m_tdata  = out_data_q;
	assign m_tuser  = {out_clp_q, out_kind_q};

	// fixed frames never report clamping
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tuser[2:0] != KIND_CONTROL) |-> !m_tuser[3])
		else $error("clamp flag on a fixed frame");

	// fixed frames carry the all-ones prefix
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tuser[2:0] != KIND_CONTROL) |-> (m_tdata[63:8] == FIXED_PREFIX))
		else $error("fixed frame prefix corrupted");

	// input backpressure only with first and last stages full and m_tready low
	assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> vld_s[0] && vld_s[NS-1] && !m_tready)
		else $error("input stalled with room in the pipeline");

endmodule

`default_nettype wire

### src/mcfe_lane.sv
// ----------------------------------------------------------------------------
// Motor command frame encoder scaling lane
// Clamps one Q16.16 value to [lo, hi] and maps it to a code in
// floor((x - lo) * (2^BITS - 1) / (hi - lo)) with a one-bit-per-stage divider.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module mcfe_lane #(
	parameter int W    = 16,
	parameter int BITS = 16
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic [W+2:0]        en,
	input  wire logic signed [31:0]  x,
	input  wire logic signed [32:0]  lo,
	input  wire logic signed [32:0]  hi,
	output logic [W-1:0]             code,
	output logic                     clamped
);
	localparam int NW = 32 + W;
	localparam int LS = W + 3;
	localparam logic [W-1:0] TOP = W'((1 << BITS) - 1);

	logic signed [33:0] span;
	logic [31:0]        span_q;
	logic               empty_q;

	logic signed [32:0] xe, xt, xc;
	logic               clp;

	logic signed [32:0] xc_s1;
	logic [31:0]        diff_s2;
	logic [NW-1:0]      prod_s3;
	logic [NW-1:0]      rem_s [W];
	logic [W-1:0]       quo_s [W];
	logic [LS-1:0]      clp_s;

	assign span = 34'(hi) - 34'(lo);

	// user changes range only when idle, unenforced; span registered off datapath
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			span_q  <= '0;
			empty_q <= 1'b1;
		end else begin
			span_q  <= span[31:0];
			empty_q <= (span <= 34'sd0);
		end
	end

	always_comb begin
		xe  = 33'(x);
		xt  = (xe > hi) ? hi : xe;
		xc  = (xt < lo) ? lo : xt;
		clp = (xe > hi) || (xt < lo);
	end

	always_ff @(posedge clk) begin
		if (en[0]) begin
			xc_s1    <= xc;
			clp_s[0] <= clp;
		end
		if (en[1]) begin
			diff_s2  <= 32'(xc_s1 - lo);
			clp_s[1] <= clp_s[0];
		end
		if (en[2]) begin
			prod_s3  <= NW'(diff_s2) * NW'(TOP);
			clp_s[2] <= clp_s[1];
		end
	end

	for (genvar k = 0; k < W; k++) begin : g_div
		localparam int J = W - 1 - k;
		logic [NW-1:0] rem_in;
		logic [W-1:0]  quo_in;
		logic [NW-1:0] dsh;

		if (k == 0) begin : g_first
			assign rem_in = prod_s3;
			assign quo_in = '0;
		end else begin : g_next
			assign rem_in = rem_s[k-1];
			assign quo_in = quo_s[k-1];
		end

		assign dsh = NW'(span_q) << J;

		always_ff @(posedge clk) begin
			if (en[3+k]) begin
				if (rem_in >= dsh) begin
					rem_s[k] <= rem_in - dsh;
					quo_s[k] <= {quo_in[W-2:0], 1'b1};
				end else begin
					rem_s[k] <= rem_in;
					quo_s[k] <= {quo_in[W-2:0], 1'b0};
				end
				clp_s[3+k] <= clp_s[2+k];
			end
		end
	end

	assign code    = empty_q ? '0 : quo_s[W-1];
	assign clamped = clp_s[LS-1];

endmodule

`default_nettype wire

### tb/sv/motor_command_frame_encoder_core_tb.sv
// ----------------------------------------------------------------------------
// Motor command frame encoder core testbench
// Streams motor commands under random stalls on both sides, predicts every
// CAN payload with an integer scaler and checks each output beat in order.
// Limits and gain ranges are rewritten over the APB port between phases.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module motor_command_frame_encoder_core_tb;
	import mcfe_pkg::*;

	localparam int LATENCY = 20;
	localparam int WATCHDOG_LIMIT = 20000;
	localparam logic [2:0] ACT_CONTROL = 3'd0;
	localparam logic [2:0] ACT_ENABLE  = 3'd1;
	localparam logic [2:0] ACT_DISABLE = 3'd2;
	localparam logic [2:0] ACT_ZERO    = 3'd3;
	localparam logic [2:0] ACT_CLEAR   = 3'd4;

	typedef struct packed {
		logic [63:0] payload;
		logic [2:0]  kind;
		logic        clamped;
	} frame_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [159:0] s_tdata = '0;
	logic [3:0] s_tuser = '0;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [63:0] m_tdata;
	logic [3:0] m_tuser;
	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [CFG_ADDR_W-1:0] paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic pready;

	motor_command_frame_encoder_core dut (.*);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// register shadow
	longint pos_lim, vel_lim, trq_lim, kp_lo, kp_hi, kd_lo, kd_hi;

	function automatic longint scale_code(longint x, longint lo, longint hi, int bits,
			ref bit clamped);
		longint span;
		span = hi - lo;
		if (x > hi) begin
			x = hi;
			clamped = 1;
		end
		if (x < lo) begin
			x = lo;
			clamped = 1;
		end
		if (span <= 0) return 0;
		return ((x - lo) * ((longint'(1) << bits) - 1)) / span;
	endfunction

	function automatic frame_t encode_frame(logic [159:0] d, logic [3:0] u);
		frame_t f;
		bit c;
		longint p, v, kp, kd, t;
		c = 0;
		f.clamped = 1'b0;
		if (u[2:0] == ACT_CONTROL && u[3]) begin
			p = scale_code(longint'($signed(d[31:0])), -pos_lim, pos_lim, 16, c);
			v = scale_code(longint'($signed(d[63:32])), -vel_lim, vel_lim, 12, c);
			kp = scale_code(longint'($signed(d[95:64])), kp_lo, kp_hi, 12, c);
			kd = scale_code(longint'($signed(d[127:96])), kd_lo, kd_hi, 12, c);
			t = scale_code(longint'($signed(d[159:128])), -trq_lim, trq_lim, 12, c);
			f.payload = {p[15:0], v[11:0], kp[11:0], kd[11:0], t[11:0]};
			f.kind = KIND_CONTROL;
			f.clamped = c;
		end else if (u[2:0] == ACT_CONTROL || u[2:0] == ACT_ENABLE) begin
			f.payload = {FIXED_PREFIX, BYTE_ENABLE};
			f.kind = KIND_ENABLE;
		end else if (u[2:0] == ACT_ZERO) begin
			f.payload = {FIXED_PREFIX, BYTE_ZERO};
			f.kind = KIND_ZERO;
		end else if (u[2:0] == ACT_CLEAR) begin
			f.payload = {FIXED_PREFIX, BYTE_CLEAR};
			f.kind = KIND_CLEAR;
		end else begin
			f.payload = {FIXED_PREFIX, BYTE_DISABLE};
			f.kind = KIND_DISABLE;
		end
		return f;
	endfunction

	class frame_scoreboard;
		frame_t pending[$];
		int mismatches = 0;
		int frames_checked = 0;
		int control_frames = 0;

		function void note_command(logic [159:0] d, logic [3:0] u);
			pending.push_back(encode_frame(d, u));
		endfunction

		function void check_frame(logic [63:0] data, logic [3:0] user);
			frame_t e;
			frames_checked++;
			if (pending.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("unexpected frame %h user %h", data, user);
				return;
			end
			e = pending.pop_front();
			if (e.kind == KIND_CONTROL) control_frames++;
			if (data !== e.payload || user[2:0] !== e.kind || user[3] !== e.clamped) begin
				mismatches++;
				if (mismatches <= 10)
					$display("mismatch: payload %h kind %0d clamp %b, expected %h %0d %b",
						data, user[2:0], user[3], e.payload, e.kind, e.clamped);
			end
		endfunction
	endclass

	frame_scoreboard sb = new();
	int idle_cycles = 0;

	always @(posedge clk) begin
		if (s_tvalid && s_tready) sb.note_command(s_tdata, s_tuser);
		if (m_tvalid && m_tready) sb.check_frame(m_tdata, m_tuser);
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || psel) idle_cycles <= 0;
		else idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("watchdog expired");
			$display("motor_command_frame_encoder_core_tb NOT OK");
			$finish;
		end
	end

	function automatic int gap_len();
		if ($urandom_range(9) < 6) return 0;
		if ($urandom_range(9) < 8) return $urandom_range(3);
		return $urandom_range(40);
	endfunction

	bit sink_free = 0;
	int sink_hold = 0;
	always @(posedge clk) begin
		if (sink_hold != 0) begin
			// hold the sink off for a long stretch
			m_tready <= 1'b0;
			sink_hold <= sink_hold - 1;
		end else if (!sink_free) m_tready <= 1'b1;
		else if ($urandom_range(9) < 7) m_tready <= 1'b1;
		else begin
			m_tready <= 1'b0;
			if ($urandom_range(19) == 0) sink_hold <= $urandom_range(40);
		end
		if ($urandom_range(99) == 0) sink_free <= ~sink_free;
	end

	task automatic reg_write(logic [2:0] index, logic [31:0] value);
		@(posedge clk);
		psel <= 1'b1;
		pwrite <= 1'b1;
		penable <= 1'b0;
		paddr <= {index, 2'b00};
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		case (index)
			REG_POS_LIMIT: pos_lim = value & 32'h7FFF_FFFF;
			REG_VEL_LIMIT: vel_lim = value & 32'h7FFF_FFFF;
			REG_TRQ_LIMIT: trq_lim = value & 32'h7FFF_FFFF;
			REG_KP_MIN: kp_lo = longint'($signed(value));
			REG_KP_MAX: kp_hi = longint'($signed(value));
			REG_KD_MIN: kd_lo = longint'($signed(value));
			default: kd_hi = longint'($signed(value));
		endcase
	endtask

	task automatic drain();
		while (sb.pending.size() != 0) @(posedge clk);
		repeat (LATENCY + 4) @(posedge clk);
	endtask

	// send one beat; valid stays high across back-to-back beats
	task automatic send_command(logic [2:0] act, logic online, logic [159:0] d);
		int g;
		g = gap_len();
		if (g != 0) begin
			s_tvalid <= 1'b0;
			repeat (g) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= {online, act};
		s_tdata <= d;
		do @(posedge clk); while (!s_tready);
	endtask

	task automatic end_burst();
		s_tvalid <= 1'b0;
		@(posedge clk);
	endtask

	function automatic logic [31:0] near_range(longint lo, longint hi);
		case ($urandom_range(5))
			0: return $urandom();
			1: return 32'(lo);
			2: return 32'(hi);
			3: return 32'(hi + $urandom_range(2) - 1);
			4: return 32'(lo + $urandom_range(2) - 1);
			default: begin
				if (hi <= lo) return 32'(lo);
				return 32'(lo + longint'($urandom()) % (hi - lo + 1));
			end
		endcase
	endfunction

	function automatic logic [159:0] random_command();
		return {near_range(-trq_lim, trq_lim), near_range(kd_lo, kd_hi),
			near_range(kp_lo, kp_hi), near_range(-vel_lim, vel_lim),
			near_range(-pos_lim, pos_lim)};
	endfunction

	task automatic random_phase(int n);
		logic [2:0] act;
		for (int i = 0; i < n; i++) begin
			act = ($urandom_range(9) < 7) ? ACT_CONTROL : 3'($urandom_range(7));
			send_command(act, ($urandom_range(9) != 0), random_command());
		end
		end_burst();
	endtask

	initial begin
		pos_lim = 819200;
		vel_lim = 1966080;
		trq_lim = 655360;
		kp_lo = 0;
		kp_hi = 32768000;
		kd_lo = 0;
		kd_hi = 327680;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: every action, offline control, field extremes
		for (int a = 0; a < 8; a++) send_command(3'(a), 1'b1, '0);
		send_command(ACT_CONTROL, 1'b0, '0);
		send_command(ACT_CONTROL, 1'b1, {5{32'h7FFF_FFFF}});
		send_command(ACT_CONTROL, 1'b1, {5{32'h8000_0000}});
		send_command(ACT_CONTROL, 1'b1, {5{32'hFFFF_FFFF}});
		send_command(ACT_CONTROL, 1'b1, {32'(trq_lim), 32'(kd_hi), 32'(kp_hi),
			32'(vel_lim), 32'(pos_lim)});
		send_command(ACT_CONTROL, 1'b1, {32'(-trq_lim), 32'(kd_lo), 32'(kp_lo),
			32'(-vel_lim), 32'(-pos_lim)});
		end_burst();
		drain();

		random_phase(200);
		drain();

		// widest ranges
		reg_write(REG_POS_LIMIT, 32'h7FFF_FFFF);
		reg_write(REG_VEL_LIMIT, 32'hFFFF_FFFF);
		reg_write(REG_TRQ_LIMIT, 32'h7FFF_FFFF);
		reg_write(REG_KP_MIN, 32'h8000_0000);
		reg_write(REG_KP_MAX, 32'h7FFF_FFFF);
		reg_write(REG_KD_MIN, 32'h8000_0000);
		reg_write(REG_KD_MAX, 32'h7FFF_FFFF);
		send_command(ACT_CONTROL, 1'b1, {5{32'h7FFF_FFFF}});
		send_command(ACT_CONTROL, 1'b1, {5{32'h8000_0000}});
		random_phase(150);
		drain();

		// narrowest and empty ranges: unit limits, swapped and equal gains
		reg_write(REG_POS_LIMIT, 32'd1);
		reg_write(REG_VEL_LIMIT, 32'h8000_0000);
		reg_write(REG_TRQ_LIMIT, 32'd1);
		reg_write(REG_KP_MIN, 32'd100);
		reg_write(REG_KP_MAX, 32'd100);
		reg_write(REG_KD_MIN, 32'd5);
		reg_write(REG_KD_MAX, 32'hFFFF_FFF0);
		random_phase(150);
		drain();

		// random ranges
		for (int ph = 0; ph < 4; ph++) begin
			for (int r = 0; r < 7; r++) reg_write(3'(r), $urandom());
			if ($urandom_range(1)) begin
				reg_write(REG_KP_MIN, 32'(-longint'($urandom_range(1 << 24))));
				reg_write(REG_KP_MAX, $urandom_range(1 << 24));
			end
			random_phase(60);
			drain();
		end

		$display("checked %0d frames, %0d control frames, over seven range settings",
			sb.frames_checked, sb.control_frames);
		if (sb.mismatches == 0 && sb.pending.size() == 0)
			$display("motor_command_frame_encoder_core_tb OK");
		else
			$display("motor_command_frame_encoder_core_tb NOT OK");
		$finish;
	end

endmodule
